FILE: hdl/swq_pkg.sv
// Package: shared codes and types for the sorted wakeup queue.
package swq_pkg;

	localparam int HANDLE_BITS = 8;

	typedef enum logic [1:0] {
		MODE_INSERT    = 2'd0,
		MODE_REM_HEAD  = 2'd1,
		MODE_REM_MATCH = 2'd2,
		MODE_NOP       = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} result_code_t;

	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LOAD  = 2'd1,
		CELL_LEFT  = 2'd2,
		CELL_RIGHT = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctl_t;

endpackage

FILE: hdl/swq_cell.sv
// One queue cell: holds an entry, compares it with a request and shifts with its neighbours.
module swq_cell
	import swq_pkg::*;
#(
	parameter int KEY_BITS = 32
) (
	input  logic                   clk,
	input  cell_ctl_t              ctl,
	input  logic                   occ,
	input  logic [KEY_BITS-1:0]    cmp_key,
	input  logic [HANDLE_BITS-1:0] cmp_handle,
	input  logic [KEY_BITS-1:0]    new_key,
	input  logic [HANDLE_BITS-1:0] new_handle,
	input  logic [KEY_BITS-1:0]    left_key,
	input  logic [HANDLE_BITS-1:0] left_handle,
	input  logic [KEY_BITS-1:0]    right_key,
	input  logic [HANDLE_BITS-1:0] right_handle,
	output logic [KEY_BITS-1:0]    key,
	output logic [HANDLE_BITS-1:0] handle,
	output logic                   gt,
	output logic                   match
);

	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;

	assign key    = key_q;
	assign handle = handle_q;
	assign gt     = occ && (key_q > cmp_key);
	assign match  = occ && (handle_q == cmp_handle);

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_LOAD: begin
				key_q    <= new_key;
				handle_q <= new_handle;
			end
			CELL_LEFT: begin
				key_q    <= left_key;
				handle_q <= left_handle;
			end
			CELL_RIGHT: begin
				key_q    <= right_key;
				handle_q <= right_handle;
			end
			default: begin
				key_q    <= key_q;
				handle_q <= handle_q;
			end
		endcase
	end

endmodule

FILE: hdl/sorted_wakeup_queue_unit.sv
// Top level: sorted wakeup queue built from a chain of entry cells.
// The compare marks are registered in stage 1; out_valid rises with the shift and the result write that follow.
// A new request is taken only while stage 1 is empty; while out_stall holds a waiting result, stage 1 stays full.
// The result register lets the next request in while a result waits to be taken.
// Reset clears the entry count, the pending flags and the mode register;
// cell contents stay unset until written.
module sorted_wakeup_queue_unit
	import swq_pkg::*;
#(
	parameter int DEPTH    = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic [HANDLE_BITS-1:0]       item_handle,
	input  logic [KEY_BITS-1:0]          sort_key,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [HANDLE_BITS-1:0]       out_handle,
	output logic [KEY_BITS-1:0]          out_key,
	output logic [$clog2(DEPTH+1)-1:0]   entry_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [DEPTH-1:0] ONE_V = DEPTH'(1);

	logic                   ordered_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   s1_valid_q;
	mode_t                  mode_s1;
	logic [HANDLE_BITS-1:0] handle_s1;
	logic [KEY_BITS-1:0]    key_s1;
	logic [DEPTH-1:0]       v_s1;

	logic                   out_valid_q;
	result_code_t           status_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [KEY_BITS-1:0]    out_key_q;
	logic [CNT_W-1:0]       entry_count_q;

	logic [DEPTH-1:0]       occ;
	logic [DEPTH-1:0]       gt;
	logic [DEPTH-1:0]       match;
	logic [KEY_BITS-1:0]    cell_key    [DEPTH];
	logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
	cell_ctl_t              cell_ctl    [DEPTH];

	logic                   accept;
	logic                   done;
	logic                   full;
	logic                   empty;
	logic [DEPTH-1:0]       v_next;
	logic [DEPTH-1:0]       first;
	logic [DEPTH-1:0]       from_pos;
	logic                   do_ins;
	logic                   do_rem;
	result_code_t           status_next;
	logic [KEY_BITS-1:0]    sel_key;
	logic [HANDLE_BITS-1:0] sel_handle;

	assign in_stall    = s1_valid_q;
	assign accept      = in_valid && !in_stall;
	assign done        = s1_valid_q && (!out_valid_q || !out_stall);
	assign full        = (cnt_q == CNT_W'(DEPTH));
	assign empty       = (cnt_q == '0);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_handle  = out_handle_q;
	assign out_key     = out_key_q;
	assign entry_count = entry_count_q;

	// cell chain
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [KEY_BITS-1:0]    lk;
		logic [HANDLE_BITS-1:0] lh;
		logic [KEY_BITS-1:0]    rk;
		logic [HANDLE_BITS-1:0] rh;

		assign occ[g] = (cnt_q > CNT_W'(g));

		if (g == 0) begin : g_head
			assign lk = key_s1;
			assign lh = handle_s1;
		end else begin : g_mid
			assign lk = cell_key[g-1];
			assign lh = cell_handle[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign rk = cell_key[g];
			assign rh = cell_handle[g];
		end else begin : g_body
			assign rk = cell_key[g+1];
			assign rh = cell_handle[g+1];
		end

		swq_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk         (clk),
			.ctl         (cell_ctl[g]),
			.occ         (occ[g]),
			.cmp_key     (sort_key),
			.cmp_handle  (item_handle),
			.new_key     (key_s1),
			.new_handle  (handle_s1),
			.left_key    (lk),
			.left_handle (lh),
			.right_key   (rk),
			.right_handle(rh),
			.key         (cell_key[g]),
			.handle      (cell_handle[g]),
			.gt          (gt[g]),
			.match       (match[g])
		);
	end

	// stage 1: mark candidate positions; free cells count as greater so an insert lands at the tail
	always_comb begin
		case (mode_t'(mode))
			MODE_INSERT:    v_next = (ordered_q ? gt : '0) | ~occ;
			MODE_REM_HEAD:  v_next = ONE_V;
			MODE_REM_MATCH: v_next = match;
			default:        v_next = '0;
		endcase
	end

	// stage 2: isolate the first marked cell and everything from it to the tail
	assign first    = v_s1 & (~v_s1 + ONE_V);
	assign from_pos = ~(first - ONE_V);

	always_comb begin
		status_next = ST_OK;
		do_ins      = 1'b0;
		do_rem      = 1'b0;
		case (mode_s1)
			MODE_INSERT: begin
				if (full) status_next = ST_FULL;
				else      do_ins      = 1'b1;
			end
			MODE_REM_HEAD: begin
				if (empty) status_next = ST_EMPTY;
				else       do_rem      = 1'b1;
			end
			MODE_REM_MATCH: begin
				if (empty)           status_next = ST_EMPTY;
				else if (v_s1 == '0) status_next = ST_NOT_FOUND;
				else                 do_rem      = 1'b1;
			end
			default: begin
				status_next = ST_OK;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i].op = CELL_HOLD;
			if (done && do_ins) begin
				if (first[i])         cell_ctl[i].op = CELL_LOAD;
				else if (from_pos[i]) cell_ctl[i].op = CELL_LEFT;
			end else if (done && do_rem && from_pos[i]) begin
				cell_ctl[i].op = CELL_RIGHT;
			end
		end
	end

	always_comb begin
		sel_key    = '0;
		sel_handle = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_key    = sel_key    | (first[i] ? cell_key[i]    : '0);
			sel_handle = sel_handle | (first[i] ? cell_handle[i] : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ordered_q   <= 1'b0;
			cnt_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) ordered_q <= cfg_wdata;
			if (accept)    s1_valid_q <= 1'b1;
			else if (done) s1_valid_q <= 1'b0;
			if (done && do_ins)      cnt_q <= cnt_q + CNT_W'(1);
			else if (done && do_rem) cnt_q <= cnt_q - CNT_W'(1);
			out_valid_q <= done || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= mode_t'(mode);
			handle_s1 <= item_handle;
			key_s1    <= sort_key;
			v_s1      <= v_next;
		end
		if (done) begin
			status_q      <= status_next;
			out_handle_q  <= do_rem ? sel_handle : '0;
			out_key_q     <= do_rem ? sel_key : '0;
			if (do_ins)      entry_count_q <= cnt_q + CNT_W'(1);
			else if (do_rem) entry_count_q <= cnt_q - CNT_W'(1);
			else             entry_count_q <= cnt_q;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_FULL) |-> (entry_count_q == CNT_W'(DEPTH)))
		else $error("full reported with free cells");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_EMPTY) |-> (entry_count_q == '0))
		else $error("empty reported with entries held");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && do_ins) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("insert did not grow the queue");

endmodule

FILE: tb/tb_top.sv
// Testbench for the sorted wakeup queue: random and directed requests checked against a shadow queue.
module tb_top;
	import swq_pkg::*;

	localparam int DEPTH      = 64;
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = $clog2(DEPTH + 1);
	localparam int LONG_HOLD  = 300;

	typedef struct packed {
		mode_t                  op;
		logic [HANDLE_BITS-1:0] handle;
		logic [KEY_BITS-1:0]    key;
	} wakeup_req_t;

	typedef struct packed {
		result_code_t           status;
		logic [HANDLE_BITS-1:0] handle;
		logic [KEY_BITS-1:0]    key;
		logic [COUNT_BITS-1:0]  count;
	} queue_result_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   cfg_we      = 1'b0;
	logic                   cfg_wdata   = 1'b0;
	logic                   in_valid    = 1'b0;
	logic                   in_stall;
	logic [1:0]             mode        = '0;
	logic [HANDLE_BITS-1:0] item_handle = '0;
	logic [KEY_BITS-1:0]    sort_key    = '0;
	logic                   out_valid;
	logic                   out_stall   = 1'b0;
	logic [1:0]             status;
	logic [HANDLE_BITS-1:0] out_handle;
	logic [KEY_BITS-1:0]    out_key;
	logic [COUNT_BITS-1:0]  entry_count;

	// shadow of the queue contents and the mode register
	logic [KEY_BITS-1:0]    shadow_keys[$];
	logic [HANDLE_BITS-1:0] shadow_handles[$];
	logic                   ordered_cfg = 1'b0;

	wakeup_req_t   request_backlog[$];
	queue_result_t outcome_fifo[$];
	wakeup_req_t   offered;
	logic          offer_taken   = 1'b0;
	int            requests_issued = 0;
	int            requests_taken  = 0;
	int            fault_count     = 0;
	int            send_gap        = 0;
	int            recv_wait       = 0;
	logic          idle_on         = 1'b1;
	logic          hold_request    = 1'b0;

	sorted_wakeup_queue_unit #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.item_handle(item_handle),
		.sort_key(sort_key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_handle(out_handle),
		.out_key(out_key),
		.entry_count(entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic queue_result_t queue_request_outcome(wakeup_req_t r);
		queue_result_t res;
		int pos;
		res.status = ST_OK;
		res.handle = '0;
		res.key    = '0;
		case (r.op)
			MODE_INSERT: begin
				if (shadow_keys.size() >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					pos = shadow_keys.size();
					if (ordered_cfg) begin
						// stable: go before the first key that is greater, so equal keys stay ahead
						pos = 0;
						while (pos < shadow_keys.size() && shadow_keys[pos] <= r.key)
							pos++;
					end
					shadow_keys.insert(pos, r.key);
					shadow_handles.insert(pos, r.handle);
				end
			end
			MODE_REM_HEAD: begin
				if (shadow_keys.size() == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.handle = shadow_handles.pop_front();
					res.key    = shadow_keys.pop_front();
				end
			end
			MODE_REM_MATCH: begin
				if (shadow_keys.size() == 0) begin
					res.status = ST_EMPTY;
				end else begin
					pos = 0;
					while (pos < shadow_handles.size() && shadow_handles[pos] != r.handle)
						pos++;
					if (pos >= shadow_handles.size()) begin
						res.status = ST_NOT_FOUND;
					end else begin
						res.handle = shadow_handles[pos];
						res.key    = shadow_keys[pos];
						shadow_handles.delete(pos);
						shadow_keys.delete(pos);
					end
				end
			end
			default: ;
		endcase
		res.count = COUNT_BITS'(shadow_keys.size());
		return res;
	endfunction

	// accept side: predict at the edge where the request is taken
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			outcome_fifo.push_back(queue_request_outcome(offered));
			requests_taken++;
			offer_taken = 1'b1;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (!in_valid || offer_taken) begin
			offer_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				send_gap = $urandom_range(1, 17) - 1;
				in_valid <= 1'b0;
			end else if (request_backlog.size() > 0) begin
				offered = request_backlog.pop_front();
				mode        <= offered.op;
				item_handle <= offered.handle;
				sort_key    <= offered.key;
				in_valid    <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver: random stall bursts plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			recv_wait = LONG_HOLD;
		end
		if (recv_wait > 0) begin
			recv_wait--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			recv_wait = $urandom_range(1, 17) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		queue_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (outcome_fifo.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result: status %0d handle %0d key %h count %0d",
						status, out_handle, out_key, entry_count);
			end else begin
				want = outcome_fifo.pop_front();
				if (status !== want.status || out_handle !== want.handle ||
						out_key !== want.key || entry_count !== want.count) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch (exp/got): status %0d/%0d handle %0d/%0d key %h/%h count %0d/%0d",
							want.status, status, want.handle, out_handle,
							want.key, out_key, want.count, entry_count);
				end
			end
		end
	end

	function automatic logic all_settled();
		return requests_taken == requests_issued && outcome_fifo.size() == 0;
	endfunction

	function automatic logic [HANDLE_BITS-1:0] pick_handle();
		// mostly a small set so that remove-by finds matches
		if ($urandom_range(0, 3) == 0)
			return HANDLE_BITS'($urandom);
		return HANDLE_BITS'($urandom_range(0, 15));
	endfunction

	function automatic logic [KEY_BITS-1:0] pick_key();
		case ($urandom_range(0, 3))
			1: return KEY_BITS'($urandom_range(0, 7));
			2: return $urandom_range(0, 1) ? '1 : '0;
			default: return KEY_BITS'($urandom);
		endcase
	endfunction

	task automatic push_request(mode_t op, logic [HANDLE_BITS-1:0] h, logic [KEY_BITS-1:0] k);
		wakeup_req_t r;
		r.op     = op;
		r.handle = h;
		r.key    = k;
		request_backlog.push_back(r);
		requests_issued++;
	endtask

	// write the mode register once the queue has nothing in flight
	task automatic write_ordered(logic v);
		while (!all_settled())
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		ordered_cfg = v;
		@(posedge clk);
	endtask

	task automatic random_phase(int count, int insert_pct, logic with_idle);
		int r;
		idle_on = with_idle;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				push_request(MODE_NOP, pick_handle(), pick_key());
			else if (r < insert_pct)
				push_request(MODE_INSERT, pick_handle(), pick_key());
			else if (r % 2 == 0)
				push_request(MODE_REM_HEAD, pick_handle(), pick_key());
			else
				push_request(MODE_REM_MATCH, pick_handle(), pick_key());
		end
	endtask

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// FIFO mode: empty removes, idle op, extremes, miss and hit on remove-by
		write_ordered(1'b0);
		push_request(MODE_REM_HEAD, 8'h00, 32'h0);
		push_request(MODE_REM_MATCH, 8'h00, 32'h0);
		push_request(MODE_NOP, 8'hFF, 32'hFFFF_FFFF);
		push_request(MODE_INSERT, 8'h00, 32'h0);
		push_request(MODE_INSERT, 8'hFF, 32'hFFFF_FFFF);
		push_request(MODE_INSERT, 8'h5A, 32'd7);
		push_request(MODE_REM_MATCH, 8'h33, 32'h0);
		push_request(MODE_REM_MATCH, 8'hFF, 32'h0);
		push_request(MODE_REM_HEAD, 8'h00, 32'h0);
		push_request(MODE_REM_HEAD, 8'h00, 32'h0);
		push_request(MODE_REM_HEAD, 8'h00, 32'h0);

		// ordered mode: equal keys keep arrival order
		write_ordered(1'b1);
		push_request(MODE_INSERT, 8'd1, 32'd5);
		push_request(MODE_INSERT, 8'd2, 32'd3);
		push_request(MODE_INSERT, 8'd3, 32'd5);
		push_request(MODE_INSERT, 8'd4, 32'hFFFF_FFFF);
		push_request(MODE_INSERT, 8'd5, 32'd0);
		push_request(MODE_REM_HEAD, 8'd0, 32'd0);
		push_request(MODE_REM_MATCH, 8'd3, 32'd0);

		// switch mode with entries held: append, then ordered inserts into the mixed order
		write_ordered(1'b0);
		push_request(MODE_INSERT, 8'd6, 32'd1);
		write_ordered(1'b1);
		push_request(MODE_INSERT, 8'd7, 32'd4);
		push_request(MODE_INSERT, 8'd8, 32'd2);

		write_ordered(1'b0);
		random_phase(300, 50, 1'b1);

		// insert-heavy with a long receiver hold-off: fill up and hit full
		write_ordered(1'b1);
		random_phase(300, 78, 1'b1);
		hold_request = 1'b1;

		write_ordered(1'b1);
		random_phase(300, 30, 1'($urandom_range(0, 1)));

		write_ordered(1'b0);
		random_phase(300, 58, 1'b1);

		write_ordered(1'b1);
		random_phase(300, 60, 1'($urandom_range(0, 1)));

		write_ordered(1'b0);
		random_phase(200, 45, 1'b1);

		// last stretch runs flat out
		write_ordered(1'b1);
		random_phase(300, 55, 1'b0);

		while (!all_settled())
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/swq_pkg.sv
hdl/swq_cell.sv
hdl/sorted_wakeup_queue_unit.sv
tb/tb_top.sv
